FILE: hw/rtl/ph_pkg.sv
// Shared constants and codes for the perfect hash membership lookup.
package ph_pkg;

	localparam int KEY_BITS    = 32;
	localparam int COLS        = KEY_BITS + 1;
	localparam int COL_AW      = $clog2(COLS);
	localparam int LABEL_DEPTH = 4096;
	localparam int KEY_DEPTH   = 1024;
	localparam int LABEL_W     = 10;
	localparam int SLOT_W      = 10;
	localparam int TS_W        = 13;
	localparam int NK_W        = 11;
	localparam int IDX_W       = 12;
	localparam int VAL_W       = 32;
	localparam int LADDR_W     = $clog2(LABEL_DEPTH);
	localparam int KADDR_W     = $clog2(KEY_DEPTH);
	localparam int MOD_STAGES  = 8;
	localparam int MOD_BITS    = VAL_W / MOD_STAGES;
	localparam int KMOD_HI     = 6;
	localparam int KMOD_LO     = NK_W - KMOD_HI;

	typedef enum logic [1:0] {
		CMD_COL   = 2'd0,
		CMD_LABEL = 2'd1,
		CMD_KEY   = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_TABLE_SIZE = 1'b0,
		REG_NUM_KEYS   = 1'b1
	} reg_t;

endpackage

FILE: hw/rtl/ph_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/perfect_hash_membership_lookup.sv
// Perfect hash membership lookup: two GF(2) hashes, label sum, key slot compare.
// A query's result comes out of the last of 15 register stages.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Modulo units: 8 stages of 4 remainder steps for the table, then 6 and 5 steps for the key count.
// Reset clears valid bits and sets table_size = 2, num_keys = 1; memories are not cleared.
module perfect_hash_membership_lookup (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               cmd,
	input  logic                     which_hash,
	input  logic [ph_pkg::IDX_W-1:0] entry_index,
	input  logic [ph_pkg::VAL_W-1:0] entry_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic [ph_pkg::SLOT_W-1:0] slot,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [ph_pkg::TS_W-1:0]  cfg_data
);

	typedef struct packed {
		logic [1:0]               cmd;
		logic [ph_pkg::IDX_W-1:0] idx;
		logic [ph_pkg::VAL_W-1:0] val;
	} item_t;

	// restoring remainder step for the table modulus
	function automatic logic [ph_pkg::TS_W-1:0] tstep(input logic [ph_pkg::TS_W-1:0] r,
			input logic b, input logic [ph_pkg::TS_W-1:0] m);
		logic [ph_pkg::TS_W:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[ph_pkg::TS_W-1:0];
	endfunction

	// restoring remainder step for the key count modulus
	function automatic logic [ph_pkg::NK_W-1:0] kstep(input logic [ph_pkg::NK_W-1:0] r,
			input logic b, input logic [ph_pkg::NK_W-1:0] m);
		logic [ph_pkg::NK_W:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[ph_pkg::NK_W-1:0];
	endfunction

	logic adv;
	logic accept;

	// clamped moduli
	logic [ph_pkg::TS_W-1:0] tmod_q;
	logic [ph_pkg::NK_W-1:0] kmod_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmod_q <= ph_pkg::TS_W'(2);
			kmod_q <= ph_pkg::NK_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ph_pkg::REG_TABLE_SIZE: begin
					if (cfg_data == '0) begin
						tmod_q <= ph_pkg::TS_W'(1);
					end else if (cfg_data > ph_pkg::TS_W'(ph_pkg::LABEL_DEPTH)) begin
						tmod_q <= ph_pkg::TS_W'(ph_pkg::LABEL_DEPTH);
					end else begin
						tmod_q <= cfg_data;
					end
				end
				ph_pkg::REG_NUM_KEYS: begin
					if (cfg_data[ph_pkg::NK_W-1:0] == '0) begin
						kmod_q <= ph_pkg::NK_W'(1);
					end else if (cfg_data[ph_pkg::NK_W-1:0] > ph_pkg::NK_W'(ph_pkg::KEY_DEPTH)) begin
						kmod_q <= ph_pkg::NK_W'(ph_pkg::KEY_DEPTH);
					end else begin
						kmod_q <= cfg_data[ph_pkg::NK_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline advances unless a result is stalled at the output
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// hash columns: written at transfer, read at fixed places
	logic [ph_pkg::VAL_W-1:0] col_q [2][ph_pkg::COLS];

	always_ff @(posedge clk) begin
		if (accept && cmd == ph_pkg::CMD_COL && entry_index <= ph_pkg::IDX_W'(ph_pkg::KEY_BITS)) begin
			col_q[which_hash][entry_index[ph_pkg::COL_AW-1:0]] <= entry_value;
		end
	end

	// GF(2) matrix product of the key with each column set
	logic [ph_pkg::VAL_W-1:0] xr [2];

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			xr[h] = '0;
			for (int b = 0; b < ph_pkg::KEY_BITS; b++) begin
				if (entry_value[b]) begin
					xr[h] = xr[h] ^ col_q[h][b];
				end
			end
		end
	end

	// stage 1: xor result and offsets
	logic                     v_s1;
	item_t                    item_s1;
	logic [ph_pkg::VAL_W-1:0] x_s1 [2];
	logic [ph_pkg::VAL_W-1:0] o_s1 [2];
	// stage 2: offset added
	logic                     v_s2;
	item_t                    item_s2;
	logic [ph_pkg::VAL_W-1:0] h_s2 [2];
	// table modulo stages
	logic                     v_sm    [ph_pkg::MOD_STAGES];
	item_t                    item_sm [ph_pkg::MOD_STAGES];
	logic [ph_pkg::TS_W-1:0]  rem_sm  [ph_pkg::MOD_STAGES][2];
	logic [ph_pkg::VAL_W-1:0] dvd_sm  [ph_pkg::MOD_STAGES][2];
	logic [ph_pkg::TS_W-1:0]  rem_nx  [ph_pkg::MOD_STAGES][2];
	logic [ph_pkg::VAL_W-1:0] dvd_nx  [ph_pkg::MOD_STAGES][2];
	// label read stage
	logic                       v_sl;
	item_t                      item_sl;
	logic [ph_pkg::LABEL_W-1:0] lab_rd [2];
	// label sum stage
	logic                    v_ss;
	item_t                   item_ss;
	logic [ph_pkg::NK_W-1:0] sum_ss;
	// key modulo stages
	logic                    v_ka, v_kb;
	item_t                   item_ka, item_kb;
	logic [ph_pkg::NK_W-1:0] rem_ka, rem_kb;
	logic [ph_pkg::KMOD_LO-1:0] dvd_ka;
	logic [ph_pkg::NK_W-1:0] rem_ka_nx, rem_kb_nx;
	// output stage
	logic                     v_o;
	item_t                    item_o;
	logic [ph_pkg::SLOT_W-1:0] slot_o;
	logic [ph_pkg::VAL_W-1:0] key_rd;

	// restoring remainder, MOD_BITS dividend bits per stage
	always_comb begin
		for (int k = 0; k < ph_pkg::MOD_STAGES; k++) begin
			for (int h = 0; h < 2; h++) begin
				if (k == 0) begin
					rem_nx[k][h] = '0;
					dvd_nx[k][h] = h_s2[h];
				end else begin
					rem_nx[k][h] = rem_sm[k-1][h];
					dvd_nx[k][h] = dvd_sm[k-1][h];
				end
				for (int j = 0; j < ph_pkg::MOD_BITS; j++) begin
					rem_nx[k][h] = tstep(rem_nx[k][h], dvd_nx[k][h][ph_pkg::VAL_W-1], tmod_q);
					dvd_nx[k][h] = {dvd_nx[k][h][ph_pkg::VAL_W-2:0], 1'b0};
				end
			end
		end
	end

	// key count remainder, high then low bits of the label sum
	always_comb begin
		rem_ka_nx = '0;
		for (int j = ph_pkg::NK_W - 1; j >= ph_pkg::KMOD_LO; j--) begin
			rem_ka_nx = kstep(rem_ka_nx, sum_ss[j], kmod_q);
		end
		rem_kb_nx = rem_ka;
		for (int j = ph_pkg::KMOD_LO - 1; j >= 0; j--) begin
			rem_kb_nx = kstep(rem_kb_nx, dvd_ka[j], kmod_q);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < ph_pkg::MOD_STAGES; k++) begin
				v_sm[k] <= 1'b0;
			end
			v_sl <= 1'b0;
			v_ss <= 1'b0;
			v_ka <= 1'b0;
			v_kb <= 1'b0;
			v_o  <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			for (int k = 0; k < ph_pkg::MOD_STAGES; k++) begin
				v_sm[k] <= (k == 0) ? v_s2 : v_sm[k-1];
			end
			v_sl <= v_sm[ph_pkg::MOD_STAGES-1];
			v_ss <= v_sl;
			v_ka <= v_ss;
			v_kb <= v_ka;
			v_o  <= v_kb;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= '{cmd: cmd, idx: entry_index, val: entry_value};
			for (int h = 0; h < 2; h++) begin
				x_s1[h] <= xr[h];
				o_s1[h] <= col_q[h][ph_pkg::KEY_BITS];
				h_s2[h] <= x_s1[h] + o_s1[h];
			end
			item_s2 <= item_s1;
			for (int k = 0; k < ph_pkg::MOD_STAGES; k++) begin
				item_sm[k] <= (k == 0) ? item_s2 : item_sm[k-1];
				for (int h = 0; h < 2; h++) begin
					rem_sm[k][h] <= rem_nx[k][h];
					dvd_sm[k][h] <= dvd_nx[k][h];
				end
			end
			item_sl <= item_sm[ph_pkg::MOD_STAGES-1];
			item_ss <= item_sl;
			sum_ss  <= ph_pkg::NK_W'(lab_rd[0]) + ph_pkg::NK_W'(lab_rd[1]);
			item_ka <= item_ss;
			rem_ka  <= rem_ka_nx;
			dvd_ka  <= sum_ss[ph_pkg::KMOD_LO-1:0];
			item_kb <= item_ka;
			rem_kb  <= rem_kb_nx;
			item_o  <= item_kb;
			slot_o  <= rem_kb[ph_pkg::SLOT_W-1:0];
		end
	end

	// label memories, one copy per hash; writes land in order with reads
	logic lab_we;

	assign lab_we = adv && v_sm[ph_pkg::MOD_STAGES-1]
		&& item_sm[ph_pkg::MOD_STAGES-1].cmd == ph_pkg::CMD_LABEL;

	for (genvar h = 0; h < 2; h++) begin : g_lab
		ph_ram #(
			.WIDTH(ph_pkg::LABEL_W),
			.DEPTH(ph_pkg::LABEL_DEPTH)
		) u_lab (
			.clk  (clk),
			.we   (lab_we),
			.waddr(item_sm[ph_pkg::MOD_STAGES-1].idx[ph_pkg::LADDR_W-1:0]),
			.wdata(item_sm[ph_pkg::MOD_STAGES-1].val[ph_pkg::LABEL_W-1:0]),
			.re   (adv),
			.raddr(rem_sm[ph_pkg::MOD_STAGES-1][h][ph_pkg::LADDR_W-1:0]),
			.rdata(lab_rd[h])
		);
	end

	// key slot memory
	logic key_we;

	assign key_we = adv && v_kb && item_kb.cmd == ph_pkg::CMD_KEY
		&& item_kb.idx[ph_pkg::IDX_W-1:ph_pkg::KADDR_W] == '0;

	ph_ram #(
		.WIDTH(ph_pkg::VAL_W),
		.DEPTH(ph_pkg::KEY_DEPTH)
	) u_key (
		.clk  (clk),
		.we   (key_we),
		.waddr(item_kb.idx[ph_pkg::KADDR_W-1:0]),
		.wdata(item_kb.val),
		.re   (adv),
		.raddr(rem_kb[ph_pkg::KADDR_W-1:0]),
		.rdata(key_rd)
	);

	// result
	assign out_valid = v_o && item_o.cmd == ph_pkg::CMD_QUERY;
	assign hit       = (key_rd == item_o.val);
	assign slot      = slot_o;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the perfect hash membership lookup.
module tb;

	typedef struct packed {
		bit                        hit;
		bit [ph_pkg::SLOT_W-1:0]   slot;
	} lookup_t;

	// Tracks the table contents and the lookups still owed by the block
	class member_scoreboard;
		bit [ph_pkg::VAL_W-1:0]   cols [2*ph_pkg::COLS];
		bit [ph_pkg::LABEL_W-1:0] labels [ph_pkg::LABEL_DEPTH];
		bit [ph_pkg::VAL_W-1:0]   keys [ph_pkg::KEY_DEPTH];
		bit                       col_ok [2*ph_pkg::COLS];
		bit                       lab_ok [ph_pkg::LABEL_DEPTH];
		bit                       key_ok [ph_pkg::KEY_DEPTH];
		bit [ph_pkg::TS_W-1:0]    table_size = 2;
		bit [ph_pkg::NK_W-1:0]    num_keys = 1;
		lookup_t                  lookups_due [$];
		int                       errors = 0;

		function int unsigned table_mod();
			if (table_size == 0) return 1;
			if (table_size > ph_pkg::LABEL_DEPTH) return ph_pkg::LABEL_DEPTH;
			return table_size;
		endfunction

		function int unsigned key_mod();
			if (num_keys == 0) return 1;
			if (num_keys > ph_pkg::KEY_DEPTH) return ph_pkg::KEY_DEPTH;
			return num_keys;
		endfunction

		// First-level hash: XOR of selected columns, plus offset, mod table size
		function int unsigned label_index(int w, bit [ph_pkg::VAL_W-1:0] key);
			bit [31:0] acc;
			acc = 0;
			for (int b = 0; b < ph_pkg::KEY_BITS; b++)
				if (key[b]) acc ^= cols[w*ph_pkg::COLS + b];
			acc += cols[w*ph_pkg::COLS + ph_pkg::KEY_BITS];
			return acc % table_mod();
		endfunction

		function int unsigned slot_of(bit [ph_pkg::VAL_W-1:0] key);
			int unsigned u, v;
			u = label_index(0, key);
			v = label_index(1, key);
			return (32'(labels[u]) + 32'(labels[v])) % key_mod();
		endfunction

		function void write_reg(ph_pkg::reg_t r, bit [ph_pkg::TS_W-1:0] d);
			if (r == ph_pkg::REG_TABLE_SIZE) table_size = d;
			else num_keys = d[ph_pkg::NK_W-1:0];
		endfunction

		// Called on every accepted input transfer
		function void note_input(ph_pkg::cmd_t c, bit w, bit [ph_pkg::IDX_W-1:0] idx,
				bit [ph_pkg::VAL_W-1:0] val);
			lookup_t e;
			int unsigned s;
			case (c)
				ph_pkg::CMD_COL: begin
					if (idx <= ph_pkg::KEY_BITS) begin
						cols[w*ph_pkg::COLS + idx] = val;
						col_ok[w*ph_pkg::COLS + idx] = 1;
					end
				end
				ph_pkg::CMD_LABEL: begin
					labels[idx] = val[ph_pkg::LABEL_W-1:0];
					lab_ok[idx] = 1;
				end
				ph_pkg::CMD_KEY: begin
					if (idx < ph_pkg::KEY_DEPTH) begin
						keys[idx] = val;
						key_ok[idx] = 1;
					end
				end
				default: begin
					s = slot_of(val);
					e.slot = s[ph_pkg::SLOT_W-1:0];
					e.hit = (keys[s] == val);
					lookups_due = {lookups_due, e};
				end
			endcase
		endfunction

		function void check_result(bit h, bit [ph_pkg::SLOT_W-1:0] s);
			lookup_t e;
			if (lookups_due.size() == 0) begin
				$error("result with no lookup pending: hit=%0d slot=%0d", h, s);
				errors++;
				return;
			end
			e = lookups_due.pop_front();
			if (h !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, h);
				errors++;
			end
			if (s !== e.slot) begin
				$error("slot: expected %0d, got %0d", e.slot, s);
				errors++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 cmd;
	logic                       which_hash;
	logic [ph_pkg::IDX_W-1:0]   entry_index;
	logic [ph_pkg::VAL_W-1:0]   entry_value;
	logic                       out_valid;
	logic                       out_stall;
	logic                       hit;
	logic [ph_pkg::SLOT_W-1:0]  slot;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic                       cfg_index;
	logic [ph_pkg::TS_W-1:0]    cfg_data;

	member_scoreboard sb = new();
	bit calm;

	perfect_hash_membership_lookup dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .which_hash(which_hash), .entry_index(entry_index),
		.entry_value(entry_value),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .slot(slot),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#50000000;
		$display("FAILURE");
		$finish;
	end

	// Result side: random stall per transfer, checks each transfer
	initial begin
		int hold;
		hold = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_result(hit, slot);
				hold = calm ? 0 : $urandom_range(0, 3);
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	// One input transfer with a random gap ahead of it
	task automatic send_item(ph_pkg::cmd_t c, bit w, bit [ph_pkg::IDX_W-1:0] idx,
			bit [ph_pkg::VAL_W-1:0] val);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		which_hash <= w;
		entry_index <= idx;
		entry_value <= val;
		do @(posedge clk); while (in_stall);
		sb.note_input(c, w, idx, val);
	endtask

	// Wait for all lookups, then let the pipeline empty before touching registers
	task automatic drain();
		in_valid <= 0;
		while (sb.lookups_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(ph_pkg::reg_t r, bit [ph_pkg::TS_W-1:0] d);
		cfg_valid <= 1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.write_reg(r, d);
	endtask

	// Query: fill unwritten labels and slot first; a hit always writes its key
	task automatic run_query(bit [ph_pkg::VAL_W-1:0] key, bit want_hit);
		int unsigned u, v, s;
		u = sb.label_index(0, key);
		if (!sb.lab_ok[u])
			send_item(ph_pkg::CMD_LABEL, 1'($urandom_range(0, 1)), ph_pkg::IDX_W'(u), $urandom);
		v = sb.label_index(1, key);
		if (!sb.lab_ok[v])
			send_item(ph_pkg::CMD_LABEL, 1'($urandom_range(0, 1)), ph_pkg::IDX_W'(v), $urandom);
		s = sb.slot_of(key);
		if (want_hit)
			send_item(ph_pkg::CMD_KEY, 1'($urandom_range(0, 1)), ph_pkg::IDX_W'(s), key);
		else if (!sb.key_ok[s])
			send_item(ph_pkg::CMD_KEY, 1'($urandom_range(0, 1)), ph_pkg::IDX_W'(s), $urandom);
		send_item(ph_pkg::CMD_QUERY, 1'($urandom_range(0, 1)), ph_pkg::IDX_W'($urandom), key);
	endtask

	initial begin
		bit [ph_pkg::TS_W-1:0] ts_set [8];
		bit [ph_pkg::TS_W-1:0] nk_set [8];
		bit [ph_pkg::VAL_W-1:0] key;
		int pick;

		ts_set = '{2, 4096, 0, 8191, 7, 100, 4096, 13};
		nk_set = '{1, 1024, 0, 8191, 5, 37, 1024, 3};
		arst_n = 0;
		in_valid = 0;
		cmd = ph_pkg::CMD_COL;
		which_hash = 0;
		entry_index = 0;
		entry_value = 0;
		cfg_valid = 0;
		cfg_index = ph_pkg::REG_TABLE_SIZE;
		cfg_data = 0;
		calm = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Load both hash matrices, extremes first
		send_item(ph_pkg::CMD_COL, 1'b0, '0, 32'h0);
		send_item(ph_pkg::CMD_COL, 1'b1, '0, 32'hFFFF_FFFF);
		for (int w = 0; w < 2; w++)
			for (int c = 1; c <= ph_pkg::KEY_BITS; c++)
				send_item(ph_pkg::CMD_COL, 1'(w), ph_pkg::IDX_W'(c), $urandom);

		// Directed: ignored writes, extreme keys, hit and miss, default registers
		send_item(ph_pkg::CMD_COL, 1'b1, ph_pkg::IDX_W'(ph_pkg::KEY_BITS + 1), 32'hFFFF_FFFF);
		send_item(ph_pkg::CMD_COL, 1'b0, 12'hFFF, 32'h0);
		send_item(ph_pkg::CMD_KEY, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
		send_item(ph_pkg::CMD_KEY, 1'b0, ph_pkg::IDX_W'(ph_pkg::KEY_DEPTH), 32'h0);
		send_item(ph_pkg::CMD_LABEL, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
		send_item(ph_pkg::CMD_LABEL, 1'b0, '0, 32'hFFFF_FC00);
		run_query(32'h0, 1'b1);
		run_query(32'hFFFF_FFFF, 1'b1);
		run_query(32'h0000_0001, 1'b0);
		run_query(32'h8000_0000, 1'b0);
		run_query(32'hFFFF_FFFF, 1'b0);

		for (int p = 0; p < 8; p++) begin
			drain();
			write_cfg(ph_pkg::REG_TABLE_SIZE, ts_set[p]);
			write_cfg(ph_pkg::REG_NUM_KEYS, nk_set[p]);
			calm = (p % 3 == 2);
			for (int i = 0; i < 100; i++) begin
				pick = $urandom_range(0, 9);
				case ($urandom_range(0, 7))
					0: key = 32'h0;
					1: key = 32'hFFFF_FFFF;
					default: key = $urandom;
				endcase
				if (pick < 7) begin
					run_query(key, 1'($urandom_range(0, 1)));
				end else if (pick == 7) begin
					send_item(ph_pkg::CMD_LABEL, 1'($urandom_range(0, 1)),
						ph_pkg::IDX_W'($urandom), $urandom);
				end else if (pick == 8) begin
					send_item(ph_pkg::CMD_KEY, 1'($urandom_range(0, 1)),
						ph_pkg::IDX_W'($urandom), $urandom);
				end else begin
					send_item(ph_pkg::CMD_COL, 1'($urandom_range(0, 1)),
						ph_pkg::IDX_W'($urandom_range(0, 40)), $urandom);
				end
			end
		end

		drain();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
